// ===== rtl/torus_wireframe_segments_top_defines.svh =====
// Assertion macros for the torus wireframe segment generator
`ifndef TORUS_WIREFRAME_SEGMENTS_TOP_DEFINES_SVH
`define TORUS_WIREFRAME_SEGMENTS_TOP_DEFINES_SVH

`ifndef SYNTH
`define TWS_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("tws assertion failed");
`define TWS_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("tws assertion failed");
`else
`define TWS_ASSERT_IMP(lbl, ante, cons)
`define TWS_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

// ===== rtl/tws_pkg.sv =====
// Shared types, constants and helpers of the torus wireframe segment generator
package tws_pkg;

    localparam int MAX_STEPS_DEF  = 1024;
    localparam int PHASE_BITS_DEF = 16;

    localparam int IDX_W     = 10;
    localparam int STEPS_W   = 11;
    localparam int RAD_W     = 16;
    localparam int COORD_W   = 19;
    localparam int EP_W      = 2;
    localparam int CFG_IDX_W = 2;
    localparam int IN_DATA_W  = 24;
    localparam int OUT_DATA_W = 64;

    localparam int CORDIC_ITERS = 16;
    localparam int CORDIC_LAT   = CORDIC_ITERS + 2;
    localparam int CW           = 34;
    localparam int TRIG_W       = 18;
    localparam logic signed [CW-1:0] CORDIC_GAIN = 34'sd652032874;

    localparam logic [RAD_W-1:0]   RING_RADIUS_RST = 16'd2560;
    localparam logic [RAD_W-1:0]   TUBE_RADIUS_RST = 16'd5120;
    localparam logic [STEPS_W-1:0] RING_STEPS_RST  = 11'd100;
    localparam logic [STEPS_W-1:0] TUBE_STEPS_RST  = 11'd100;

    localparam logic signed [63:0] COORD_MAX = 64'sd262143;
    localparam logic signed [63:0] COORD_MIN = -64'sd262144;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RING_RADIUS,
        CFG_TUBE_RADIUS,
        CFG_RING_STEPS,
        CFG_TUBE_STEPS
    } t_cfg_idx;

    localparam logic [EP_W-1:0] EP_CELL  = 2'd0;
    localparam logic [EP_W-1:0] EP_MINOR = 2'd1;
    localparam logic [EP_W-1:0] EP_CELL2 = 2'd2;
    localparam logic [EP_W-1:0] EP_MAJOR = 2'd3;

    typedef struct packed {
        logic            valid;
        logic [EP_W-1:0] ep;
        logic            last;
        logic            err;
    } t_meta;

    function automatic logic signed [CW-1:0] atan_turn(input int k);
        logic signed [CW-1:0] v;
        case (k)
            0:       v = 34'sd536870912;
            1:       v = 34'sd316933406;
            2:       v = 34'sd167458907;
            3:       v = 34'sd85004756;
            4:       v = 34'sd42667331;
            5:       v = 34'sd21354466;
            6:       v = 34'sd10679838;
            7:       v = 34'sd5340245;
            8:       v = 34'sd2670163;
            9:       v = 34'sd1335087;
            10:      v = 34'sd667544;
            11:      v = 34'sd333772;
            12:      v = 34'sd166886;
            13:      v = 34'sd83443;
            14:      v = 34'sd41722;
            15:      v = 34'sd20861;
            default: v = '0;
        endcase
        return v;
    endfunction

    function automatic logic signed [COORD_W-1:0] sat_coord(input logic signed [63:0] v);
        logic signed [COORD_W-1:0] r;
        if (v > COORD_MAX) begin
            r = COORD_W'(COORD_MAX);
        end else if (v < COORD_MIN) begin
            r = COORD_W'(COORD_MIN);
        end else begin
            r = COORD_W'(v);
        end
        return r;
    endfunction

endpackage

// ===== rtl/tws_div.sv =====
// Pipelined restoring divider giving the turn phase index * 2^PHASE_BITS / steps
module tws_div #(
    parameter int PHASE_BITS = tws_pkg::PHASE_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_en,
    input  logic [tws_pkg::STEPS_W-1:0] i_idx,
    input  logic [tws_pkg::STEPS_W-1:0] i_steps,
    output logic [PHASE_BITS-1:0]       o_phase
);

    logic [tws_pkg::STEPS_W-1:0] r_rem [PHASE_BITS];
    logic [PHASE_BITS-1:0]       r_q   [PHASE_BITS];

    for (genvar k = 0; k < PHASE_BITS; k++) begin : g_stage
        logic [tws_pkg::STEPS_W-1:0] w_rem_in;
        logic [PHASE_BITS-1:0]       w_q_in;
        logic [tws_pkg::STEPS_W:0]   w_rem2;
        logic                        w_ge;

        if (k == 0) begin : g_first
            assign w_rem_in = i_idx;
            assign w_q_in   = '0;
        end else begin : g_next
            assign w_rem_in = r_rem[k-1];
            assign w_q_in   = r_q[k-1];
        end

        assign w_rem2 = {w_rem_in, 1'b0};
        assign w_ge   = (w_rem2 >= {1'b0, i_steps});

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k] <= w_ge ? tws_pkg::STEPS_W'(w_rem2 - {1'b0, i_steps})
                                 : w_rem2[tws_pkg::STEPS_W-1:0];
                r_q[k]   <= {w_q_in[PHASE_BITS-2:0], w_ge};
            end
        end
    end

    assign o_phase = r_q[PHASE_BITS-1];

endmodule

// ===== rtl/tws_cordic.sv =====
// Pipelined rotation CORDIC giving Q3.15 cosine and sine of a turn phase
module tws_cordic #(
    parameter int PHASE_BITS = tws_pkg::PHASE_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_en,
    input  logic [PHASE_BITS-1:0]             i_phase,
    output logic signed [tws_pkg::TRIG_W-1:0] o_cos,
    output logic signed [tws_pkg::TRIG_W-1:0] o_sin
);

    localparam int N  = tws_pkg::CORDIC_ITERS;
    localparam int CW = tws_pkg::CW;

    logic signed [CW-1:0] r_x [N+1];
    logic signed [CW-1:0] r_y [N+1];
    logic signed [CW-1:0] r_z [N+1];
    logic                 r_flip [N+1];
    logic signed [tws_pkg::TRIG_W-1:0] r_cos;
    logic signed [tws_pkg::TRIG_W-1:0] r_sin;

    logic [31:0] w_ph;
    logic        w_flip;
    logic signed [CW-1:0] w_xf;
    logic signed [CW-1:0] w_yf;
    logic signed [CW-1:0] w_xr;
    logic signed [CW-1:0] w_yr;

    assign w_ph   = 32'(i_phase) << (32 - PHASE_BITS);
    assign w_flip = w_ph[31] ^ w_ph[30];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x[0]    <= tws_pkg::CORDIC_GAIN;
            r_y[0]    <= '0;
            r_z[0]    <= CW'(signed'({w_ph[31] ^ w_flip, w_ph[30:0]}));
            r_flip[0] <= w_flip;
        end
    end

    for (genvar k = 0; k < N; k++) begin : g_iter
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (!r_z[k][CW-1]) begin
                    r_x[k+1] <= r_x[k] - (r_y[k] >>> k);
                    r_y[k+1] <= r_y[k] + (r_x[k] >>> k);
                    r_z[k+1] <= r_z[k] - tws_pkg::atan_turn(k);
                end else begin
                    r_x[k+1] <= r_x[k] + (r_y[k] >>> k);
                    r_y[k+1] <= r_y[k] - (r_x[k] >>> k);
                    r_z[k+1] <= r_z[k] + tws_pkg::atan_turn(k);
                end
                r_flip[k+1] <= r_flip[k];
            end
        end
    end

    assign w_xf = r_flip[N] ? -r_x[N] : r_x[N];
    assign w_yf = r_flip[N] ? -r_y[N] : r_y[N];
    assign w_xr = w_xf + CW'(16384);
    assign w_yr = w_yf + CW'(16384);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_cos <= w_xr[15 +: tws_pkg::TRIG_W];
            r_sin <= w_yr[15 +: tws_pkg::TRIG_W];
        end
    end

    assign o_cos = r_cos;
    assign o_sin = r_sin;

endmodule

// ===== rtl/torus_wireframe_segments_top.sv =====
// Throughput: one result beat per cycle while the output register is free or taken.
// A cell yields four beats (CELL, MINOR, CELL2, MAJOR), an index error a single beat.
// The output register sets the pace: the whole pipeline advances when it is free or taken.
// Reset (synchronous, active low) clears all valid bits and loads the register defaults.
// Top level of the torus wireframe segment generator
`include "torus_wireframe_segments_top_defines.svh"

module torus_wireframe_segments_top #(
    parameter int MAX_STEPS  = tws_pkg::MAX_STEPS_DEF,
    parameter int PHASE_BITS = tws_pkg::PHASE_BITS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_wr_en,
    input  logic [tws_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [tws_pkg::RAD_W-1:0]        i_cfg_wdata,
    input  logic                             i_s_axis_tvalid,
    output logic                             o_s_axis_tready,
    // ring_index, tube_index
    input  logic [tws_pkg::IN_DATA_W-1:0]    i_s_axis_tdata,
    output logic                             o_m_axis_tvalid,
    input  logic                             i_m_axis_tready,
    // coord_x, coord_y, coord_z, endpoint_number
    output logic [tws_pkg::OUT_DATA_W-1:0]   o_m_axis_tdata,
    output logic                             o_m_axis_tlast,
    // index_error
    output logic [0:0]                       o_m_axis_tuser
);

    localparam int SW  = tws_pkg::STEPS_W;
    localparam int TW  = tws_pkg::TRIG_W;
    localparam int CWD = tws_pkg::COORD_W;
    localparam int LAT = PHASE_BITS + tws_pkg::CORDIC_LAT + 3;

    logic [tws_pkg::RAD_W-1:0] r_ring_radius;
    logic [tws_pkg::RAD_W-1:0] r_tube_radius;
    logic [SW-1:0]             r_ring_steps;
    logic [SW-1:0]             r_tube_steps;

    logic [SW-1:0] w_ring_steps;
    logic [SW-1:0] w_tube_steps;

    logic                      r_item_valid;
    logic [tws_pkg::IDX_W-1:0] r_ring;
    logic [tws_pkg::IDX_W-1:0] r_tube;
    logic [SW-1:0]             r_ring_nx;
    logic [SW-1:0]             r_tube_nx;
    logic                      r_item_err;
    logic [tws_pkg::EP_W-1:0]  r_cnt;

    logic                      w_adv;
    logic                      w_done;
    logic                      w_accept;
    logic                      w_issue;
    logic [tws_pkg::IDX_W-1:0] w_in_ring;
    logic [tws_pkg::IDX_W-1:0] w_in_tube;
    logic [SW-1:0]             w_job_a;
    logic [SW-1:0]             w_job_b;
    tws_pkg::t_meta            w_job_meta;

    tws_pkg::t_meta r_meta [LAT];

    logic [PHASE_BITS-1:0] w_phase_a;
    logic [PHASE_BITS-1:0] w_phase_b;
    logic signed [TW-1:0]  w_ca;
    logic signed [TW-1:0]  w_sa;
    logic signed [TW-1:0]  w_cb;
    logic signed [TW-1:0]  w_sb;

    logic signed [34:0]   r_m1_pb;
    logic signed [34:0]   r_m1_zp;
    logic signed [TW-1:0] r_m1_ca;
    logic signed [TW-1:0] r_m1_sa;
    logic signed [36:0]   r_m2_w;
    logic signed [34:0]   r_m2_zr;
    logic signed [TW-1:0] r_m2_ca;
    logic signed [TW-1:0] r_m2_sa;
    logic signed [54:0]   r_m3_px;
    logic signed [54:0]   r_m3_py;
    logic signed [19:0]   r_m3_z;
    logic signed [54:0]   w_px_r;
    logic signed [54:0]   w_py_r;

    logic                     r_out_valid;
    logic signed [CWD-1:0]    r_out_x;
    logic signed [CWD-1:0]    r_out_y;
    logic signed [CWD-1:0]    r_out_z;
    logic [tws_pkg::EP_W-1:0] r_out_ep;
    logic                     r_out_last;
    logic                     r_out_err;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ring_radius <= tws_pkg::RING_RADIUS_RST;
            r_tube_radius <= tws_pkg::TUBE_RADIUS_RST;
            r_ring_steps  <= tws_pkg::RING_STEPS_RST;
            r_tube_steps  <= tws_pkg::TUBE_STEPS_RST;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                tws_pkg::CFG_RING_RADIUS: r_ring_radius <= i_cfg_wdata;
                tws_pkg::CFG_TUBE_RADIUS: r_tube_radius <= i_cfg_wdata;
                tws_pkg::CFG_RING_STEPS:  r_ring_steps  <= i_cfg_wdata[SW-1:0];
                tws_pkg::CFG_TUBE_STEPS:  r_tube_steps  <= i_cfg_wdata[SW-1:0];
                default: ;
            endcase
        end
    end

    assign w_ring_steps = (32'(r_ring_steps) > 32'(MAX_STEPS)) ? SW'(MAX_STEPS) : r_ring_steps;
    assign w_tube_steps = (32'(r_tube_steps) > 32'(MAX_STEPS)) ? SW'(MAX_STEPS) : r_tube_steps;

    // expand a cell into its vertex jobs
    assign w_adv     = !r_out_valid || i_m_axis_tready;
    assign w_done    = r_item_err || (r_cnt == tws_pkg::EP_MAJOR);
    assign w_issue   = r_item_valid && w_adv;
    assign o_s_axis_tready = !r_item_valid || (w_adv && w_done);
    assign w_accept  = i_s_axis_tvalid && o_s_axis_tready;
    assign w_in_ring = i_s_axis_tdata[tws_pkg::IDX_W-1:0];
    assign w_in_tube = i_s_axis_tdata[2*tws_pkg::IDX_W-1:tws_pkg::IDX_W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_item_valid <= 1'b0;
            r_cnt        <= tws_pkg::EP_CELL;
        end else if (w_accept) begin
            r_item_valid <= 1'b1;
            r_cnt        <= tws_pkg::EP_CELL;
        end else if (w_issue) begin
            r_item_valid <= !w_done;
            r_cnt        <= r_cnt + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_ring     <= w_in_ring;
            r_tube     <= w_in_tube;
            r_item_err <= (SW'(w_in_ring) >= w_ring_steps) || (SW'(w_in_tube) >= w_tube_steps);
            r_ring_nx  <= (SW'(w_in_ring) + 1'b1 == w_ring_steps) ? '0 : SW'(w_in_ring) + 1'b1;
            r_tube_nx  <= (SW'(w_in_tube) + 1'b1 == w_tube_steps) ? '0 : SW'(w_in_tube) + 1'b1;
        end
    end

    assign w_job_a = (r_cnt == tws_pkg::EP_MAJOR) ? r_ring_nx : SW'(r_ring);
    assign w_job_b = (r_cnt == tws_pkg::EP_MINOR) ? r_tube_nx : SW'(r_tube);

    always_comb begin
        w_job_meta.valid = r_item_valid;
        w_job_meta.ep    = r_cnt;
        w_job_meta.last  = w_done;
        w_job_meta.err   = r_item_err;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < LAT; k++) begin
                r_meta[k] <= '0;
            end
        end else if (w_adv) begin
            r_meta[0] <= w_job_meta;
            for (int k = 1; k < LAT; k++) begin
                r_meta[k] <= r_meta[k-1];
            end
        end
    end

    tws_div #(.PHASE_BITS(PHASE_BITS)) u_div_a (
        .i_clk   (i_clk),
        .i_en    (w_adv),
        .i_idx   (w_job_a),
        .i_steps (w_ring_steps),
        .o_phase (w_phase_a)
    );

    tws_div #(.PHASE_BITS(PHASE_BITS)) u_div_b (
        .i_clk   (i_clk),
        .i_en    (w_adv),
        .i_idx   (w_job_b),
        .i_steps (w_tube_steps),
        .o_phase (w_phase_b)
    );

    tws_cordic #(.PHASE_BITS(PHASE_BITS)) u_cordic_a (
        .i_clk   (i_clk),
        .i_en    (w_adv),
        .i_phase (w_phase_a),
        .o_cos   (w_ca),
        .o_sin   (w_sa)
    );

    tws_cordic #(.PHASE_BITS(PHASE_BITS)) u_cordic_b (
        .i_clk   (i_clk),
        .i_en    (w_adv),
        .i_phase (w_phase_b),
        .o_cos   (w_cb),
        .o_sin   (w_sb)
    );

    assign w_px_r = r_m3_px + 55'sd536870912;
    assign w_py_r = r_m3_py + 55'sd536870912;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_m1_pb <= 35'(signed'({1'b0, r_tube_radius})) * 35'(w_cb);
            r_m1_zp <= 35'(signed'({1'b0, r_tube_radius})) * 35'(w_sb);
            r_m1_ca <= w_ca;
            r_m1_sa <= w_sa;
            r_m2_w  <= 37'(signed'({1'b0, r_ring_radius, 15'b0})) + 37'(r_m1_pb);
            r_m2_zr <= (r_m1_zp + 35'sd16384) >>> 15;
            r_m2_ca <= r_m1_ca;
            r_m2_sa <= r_m1_sa;
            r_m3_px <= 55'(r_m2_w) * 55'(r_m2_ca);
            r_m3_py <= 55'(r_m2_w) * 55'(r_m2_sa);
            r_m3_z  <= 20'(r_m2_zr);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= r_meta[LAT-1].valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out_ep   <= r_meta[LAT-1].ep;
            r_out_last <= r_meta[LAT-1].last;
            r_out_err  <= r_meta[LAT-1].err;
            if (r_meta[LAT-1].err) begin
                r_out_x <= '0;
                r_out_y <= '0;
                r_out_z <= '0;
            end else begin
                r_out_x <= tws_pkg::sat_coord(64'(w_px_r >>> 30));
                r_out_y <= tws_pkg::sat_coord(64'(w_py_r >>> 30));
                r_out_z <= tws_pkg::sat_coord(64'(r_m3_z));
            end
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {5'b0, r_out_ep, r_out_z, r_out_y, r_out_x};
    assign o_m_axis_tlast  = r_out_last;
    assign o_m_axis_tuser  = r_out_err;

    `TWS_ASSERT_IMP(a_err_beat_zero, o_m_axis_tvalid && o_m_axis_tuser[0], (o_m_axis_tdata == '0) && o_m_axis_tlast)
    `TWS_ASSERT_IMP(a_last_on_major, o_m_axis_tvalid && o_m_axis_tlast && !o_m_axis_tuser[0], r_out_ep == tws_pkg::EP_MAJOR)
    `TWS_ASSERT_NXT(a_accept_loads, w_accept, r_item_valid && (r_cnt == tws_pkg::EP_CELL))
    `TWS_ASSERT_NXT(a_stall_holds_cnt, r_item_valid && !w_adv, $stable(r_cnt) && r_item_valid)

endmodule

// ===== bench/tb_torus_wireframe_segments_top.sv =====
// Self-checking bench for the torus wireframe segment generator top level
module tb_torus_wireframe_segments_top;
    import tws_pkg::*;

    localparam int  LATENCY     = PHASE_BITS_DEF + 23;
    localparam int  CYCLE_LIMIT = 400000;
    localparam int  HW_STEPS    = MAX_STEPS_DEF;

    typedef struct {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [COORD_W-1:0] z;
        logic [EP_W-1:0]    ep;
        logic               last;
        logic               err;
    } vertex_t;

    localparam longint ATAN_TURNS [16] = '{
        536870912, 316933406, 167458907, 85004756, 42667331, 21354466,
        10679838, 5340245, 2670163, 1335087, 667544, 333772,
        166886, 83443, 41722, 20861
    };

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [RAD_W-1:0]      cfg_wdata = '0;
    logic                  s_tvalid = 1'b0;
    logic [IN_DATA_W-1:0]  s_tdata = '0;
    logic                  m_tready = 1'b0;
    logic                  o_s_axis_tready;
    logic                  o_m_axis_tvalid;
    logic [OUT_DATA_W-1:0] o_m_axis_tdata;
    logic                  o_m_axis_tlast;
    logic [0:0]            o_m_axis_tuser;

    logic [RAD_W-1:0]   ring_radius;
    logic [RAD_W-1:0]   tube_radius;
    logic [STEPS_W-1:0] ring_steps;
    logic [STEPS_W-1:0] tube_steps;

    vertex_t pending_vertices [$];
    int  fail_count    = 0;
    int  cells_sent    = 0;
    int  vertices_seen = 0;
    int  errors_seen   = 0;
    int  cycle_count   = 0;
    int  hold_cycles   = 0;
    int  stall_left    = 0;
    bit  steady        = 1'b0;

    torus_wireframe_segments_top u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wr_en     (cfg_wr_en),
        .i_cfg_index     (cfg_index),
        .i_cfg_wdata     (cfg_wdata),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (s_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t: timeout after %0d cycles", $realtime, cycle_count);
            $display("CHECK FAILED");
            $finish;
        end
    end

    function automatic void trig_of_phase(input logic [31:0] ph, output longint c,
                                          output longint s);
        longint      x, y, z, xn;
        logic [31:0] p;
        bit          flip;
        p    = ph;
        flip = 1'b0;
        if (((p + 32'h4000_0000) & 32'h8000_0000) != 0) begin
            p    = p - 32'h8000_0000;
            flip = 1'b1;
        end
        z = longint'($signed(p));
        x = 652032874;
        y = 0;
        for (int k = 0; k < 16; k++) begin
            if (z >= 0) begin
                xn = x - (y >>> k);
                y  = y + (x >>> k);
                z  = z - ATAN_TURNS[k];
            end else begin
                xn = x + (y >>> k);
                y  = y - (x >>> k);
                z  = z + ATAN_TURNS[k];
            end
            x = xn;
        end
        if (flip) begin
            x = -x;
            y = -y;
        end
        c = (x + 16384) >>> 15;
        s = (y + 16384) >>> 15;
    endfunction

    function automatic logic [31:0] turn_phase(input int idx, input int steps);
        longint p;
        p = ((longint'(idx) << PHASE_BITS_DEF) / steps) & ((64'd1 << PHASE_BITS_DEF) - 1);
        return 32'(p << (32 - PHASE_BITS_DEF));
    endfunction

    function automatic logic [COORD_W-1:0] clamp_coord(input longint v);
        if (v > 262143) begin
            return COORD_W'(262143);
        end else if (v < -262144) begin
            return COORD_W'(-262144);
        end
        return COORD_W'(v);
    endfunction

    function automatic vertex_t torus_vertex(input int i, input int j, input int rs,
                                             input int ts, input int ep, input bit last);
        vertex_t v;
        longint  ca, sa, cb, sb, w;
        trig_of_phase(turn_phase(i, rs), ca, sa);
        trig_of_phase(turn_phase(j, ts), cb, sb);
        w      = (longint'(ring_radius) << 15) + longint'(tube_radius) * cb;
        v.x    = clamp_coord((w * ca + (64'sd1 <<< 29)) >>> 30);
        v.y    = clamp_coord((w * sa + (64'sd1 <<< 29)) >>> 30);
        v.z    = clamp_coord((longint'(tube_radius) * sb + 16384) >>> 15);
        v.ep   = EP_W'(ep);
        v.last = last;
        v.err  = 1'b0;
        return v;
    endfunction

    function automatic void queue_vertex(input vertex_t v);
        pending_vertices.insert(pending_vertices.size(), v);
    endfunction

    function automatic void expect_cell(input int i, input int j);
        int      rs, ts, jn, inx;
        vertex_t v;
        rs = (ring_steps > HW_STEPS) ? HW_STEPS : int'(ring_steps);
        ts = (tube_steps > HW_STEPS) ? HW_STEPS : int'(tube_steps);
        if (i >= rs || j >= ts) begin
            v = '{x: '0, y: '0, z: '0, ep: EP_CELL, last: 1'b1, err: 1'b1};
            queue_vertex(v);
            return;
        end
        jn  = (j + 1 == ts) ? 0 : j + 1;
        inx = (i + 1 == rs) ? 0 : i + 1;
        v = torus_vertex(i, j, rs, ts, EP_CELL, 1'b0);
        queue_vertex(v);
        queue_vertex(torus_vertex(i, jn, rs, ts, EP_MINOR, 1'b0));
        v.ep = EP_CELL2;
        queue_vertex(v);
        queue_vertex(torus_vertex(inx, j, rs, ts, EP_MAJOR, 1'b1));
    endfunction

    task automatic compare_field(input string name, input longint exp_v, input longint act_v);
        if (exp_v != act_v) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $realtime, name, exp_v,
                     act_v);
            fail_count++;
        end
    endtask

    initial begin
        vertex_t e;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_m_axis_tvalid && m_tready) begin
                vertices_seen++;
                if (pending_vertices.size() == 0) begin
                    $display("%0t: unexpected beat, expected none, actual %h", $realtime,
                             o_m_axis_tdata);
                    fail_count++;
                end else begin
                    e = pending_vertices.pop_front();
                    if (e.err) errors_seen++;
                    compare_field("coord_x", e.x, o_m_axis_tdata[18:0]);
                    compare_field("coord_y", e.y, o_m_axis_tdata[37:19]);
                    compare_field("coord_z", e.z, o_m_axis_tdata[56:38]);
                    compare_field("endpoint", e.ep, o_m_axis_tdata[58:57]);
                    compare_field("tlast", e.last, o_m_axis_tlast);
                    compare_field("index_error", e.err, o_m_axis_tuser[0]);
                end
            end
        end
    end

    initial begin
        int n;
        forever begin
            @(posedge i_clk);
            if (hold_cycles > 0) begin
                m_tready <= 1'b0;
                hold_cycles--;
            end else if (stall_left > 0) begin
                m_tready <= 1'b0;
                stall_left--;
            end else if (m_tready && o_m_axis_tvalid && !steady) begin
                n = $urandom_range(0, 13);
                if (n > 0) begin
                    m_tready   <= 1'b0;
                    stall_left = n - 1;
                end
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    task automatic send_cell(input int i, input int j);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 13);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {4'b0, 10'(j), 10'(i)};
        do @(posedge i_clk); while (!o_s_axis_tready);
        expect_cell(i, j);
        cells_sent++;
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        wait (pending_vertices.size() == 0);
        repeat (LATENCY + 20) @(posedge i_clk);
    endtask

    task automatic set_torus(input logic [15:0] r_big, input logic [15:0] r_small,
                             input logic [15:0] rs, input logic [15:0] ts);
        logic [15:0] vals [4];
        wait_drained();
        vals = '{r_big, r_small, rs, ts};
        for (int k = 0; k < 4; k++) begin
            cfg_wr_en <= 1'b1;
            cfg_index <= CFG_IDX_W'(k);
            cfg_wdata <= vals[k];
            @(posedge i_clk);
        end
        cfg_wr_en   <= 1'b0;
        ring_radius = r_big;
        tube_radius = r_small;
        ring_steps  = rs[STEPS_W-1:0];
        tube_steps  = ts[STEPS_W-1:0];
    endtask

    task automatic send_random_cells(input int count, input int bad_pct);
        int rs, ts;
        rs = (ring_steps > HW_STEPS) ? HW_STEPS : int'(ring_steps);
        ts = (tube_steps > HW_STEPS) ? HW_STEPS : int'(tube_steps);
        for (int n = 0; n < count; n++) begin
            if (rs == 0 || ts == 0 || $urandom_range(1, 100) <= bad_pct) begin
                send_cell($urandom_range(0, 1023), $urandom_range(0, 1023));
            end else begin
                send_cell($urandom_range(0, rs - 1), $urandom_range(0, ts - 1));
            end
        end
    endtask

    task automatic test_directed();
        send_cell(0, 0);
        send_cell(99, 99);
        send_cell(99, 0);
        send_cell(0, 99);
        send_cell(100, 0);
        send_cell(0, 100);
        send_cell(1023, 1023);
        send_cell(25, 75);
        set_torus(16'd2560, 16'd5120, 16'd1024, 16'd1024);
        send_cell(1023, 1023);
        send_cell(341, 682);
        send_cell(682, 341);
        send_cell(512, 256);
        set_torus(16'd0, 16'd0, 16'd0, 16'd0);
        send_cell(0, 0);
        send_cell(5, 7);
        set_torus(16'hFFFF, 16'hFFFF, 16'h07FF, 16'hFFFF);
        send_cell(1023, 1023);
        send_cell(0, 512);
        send_cell(256, 768);
        set_torus(16'd256, 16'd128, 16'd1, 16'd1);
        send_cell(0, 0);
        send_cell(1, 0);
        send_cell(0, 1);
    endtask

    task automatic test_default_shape();
        set_torus(RING_RADIUS_RST, TUBE_RADIUS_RST, 16'(RING_STEPS_RST), 16'(TUBE_STEPS_RST));
        send_random_cells(60, 10);
    endtask

    task automatic test_random_shapes();
        for (int p = 0; p < 8; p++) begin
            set_torus(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                      (p % 3 == 0) ? 16'($urandom_range(0, 65535))
                                   : 16'($urandom_range(1, 1024)),
                      16'($urandom_range(1, 1024)));
            send_random_cells(26, 8);
        end
    endtask

    task automatic test_full_grid();
        set_torus(16'hFFFF, 16'hFFFF, 16'd1024, 16'd1024);
        send_random_cells(40, 0);
        set_torus(16'd3, 16'd1, 16'd2, 16'd3);
        send_random_cells(20, 20);
    endtask

    task automatic test_backpressure();
        set_torus(16'd4000, 16'd1500, 16'd64, 16'd48);
        hold_cycles = 400;
        send_random_cells(30, 10);
        wait_drained();
        steady = 1'b1;
        send_random_cells(30, 10);
        steady = 1'b0;
        send_random_cells(20, 10);
    endtask

    initial begin
        ring_radius = RING_RADIUS_RST;
        tube_radius = TUBE_RADIUS_RST;
        ring_steps  = RING_STEPS_RST;
        tube_steps  = TUBE_STEPS_RST;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_default_shape();
        test_random_shapes();
        test_full_grid();
        test_backpressure();
        wait_drained();
        $display("Covered %0d cells, %0d vertex beats, %0d index errors,", cells_sent,
                 vertices_seen, errors_seen);
        $display("over default, extreme, random and saturated torus shapes with stalls.");
        if (fail_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
